// ===== rtl/core/tlbpt_pkg.sv =====
// Package: shared constants and types for the TLB paging translator
package tlbpt_pkg;
	localparam int TlbEntries  = 16;
	localparam int FrameCount  = 256;
	localparam int PageCount   = 1024;
	localparam int OffsetWidth = 10;
	localparam int VaWidth     = 20;
	localparam int PaWidth     = 18;
	localparam int TlbIdxW     = $clog2(TlbEntries);
	localparam int FrameW      = $clog2(FrameCount);
	localparam int PageW       = $clog2(PageCount);
	localparam int UsedW       = FrameW + 1;

	typedef logic [PageW-1:0]  page_t;
	typedef logic [FrameW-1:0] frame_t;

	typedef struct packed {
		logic [VaWidth-1:0] virtual_address;
	} va_item_t;

	typedef struct packed {
		logic [PaWidth-1:0] phys_addr;
		logic [FrameW-1:0]  frame_number;
		logic               tlb_hit;
		logic               page_fault;
		logic               evicted_valid;
		logic [PageW-1:0]   evicted_page;
	} pa_item_t;
endpackage

// ===== rtl/core/tlbpt_if.sv =====
// Interfaces: valid/ready channels for input and result items
interface tlbpt_va_if import tlbpt_pkg::*; ();
	logic     valid;
	logic     ready;
	va_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface tlbpt_pa_if import tlbpt_pkg::*; ();
	logic     valid;
	logic     ready;
	pa_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/tlbpt_ram.sv =====
// Generic single-port RAM with registered read
module tlbpt_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] addr,
	input  logic [Width-1:0]         wdata,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

// ===== rtl/core/tlbpt_tlb.sv =====
// TLB: tag/frame registers, parallel match, clock-hand fill
module tlbpt_tlb import tlbpt_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  page_t  page,
	input  logic   mark,       // set ref bits of entries matching page
	input  logic   step,       // one clock-hand step
	input  frame_t fill_frame,
	output logic   hit,
	output frame_t hit_frame,
	output logic   hand_ref    // ref bit under the hand
);
	page_t                 tag_q [TlbEntries];
	frame_t                frm_q [TlbEntries];
	logic [TlbEntries-1:0] valid_q, ref_q, match;
	logic [TlbIdxW-1:0]    hand_q;

	// match and lowest-index priority select
	always_comb begin
		hit = 1'b0;
		hit_frame = '0;
		for (int i = 0; i < TlbEntries; i++) begin
			match[i] = valid_q[i] && tag_q[i] == page;
		end
		for (int i = TlbEntries - 1; i >= 0; i--) begin
			if (match[i]) begin
				hit = 1'b1;
				hit_frame = frm_q[i];
			end
		end
	end
	assign hand_ref = ref_q[hand_q];

	// entry payload
	always_ff @(posedge clk) begin
		if (step && !ref_q[hand_q]) begin
			tag_q[hand_q] <= page;
			frm_q[hand_q] <= fill_frame;
		end
	end

	// control bits and hand
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			ref_q <= '0;
			hand_q <= '0;
		end else if (step) begin
			if (ref_q[hand_q]) begin
				ref_q[hand_q] <= 1'b0;
			end else begin
				valid_q[hand_q] <= 1'b1;
				ref_q[hand_q] <= 1'b1;
			end
			hand_q <= hand_q + 1'b1;
		end else if (mark) begin
			ref_q <= ref_q | match;
		end
	end
endmodule

// ===== rtl/core/tlbpt_ctrl.sv =====
// Sequencer: page table, frame allocation and victim selection
module tlbpt_ctrl import tlbpt_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   policy,
	tlbpt_va_if.sink   va,
	tlbpt_pa_if.source pa,
	output page_t  page,
	output logic   tlb_mark,
	output logic   tlb_step,
	output frame_t fill_frame,
	input  logic   tlb_hit,
	input  frame_t tlb_frame,
	input  logic   tlb_hand_ref
);
	typedef enum logic [9:0] {
		ST_IDLE  = 10'b00_0000_0001,
		ST_CLEAR = 10'b00_0000_0010,
		ST_LOOK  = 10'b00_0000_0100,
		ST_MAP   = 10'b00_0000_1000,
		ST_CLOCK = 10'b00_0001_0000,
		ST_CREF  = 10'b00_0010_0000,
		ST_INVAL = 10'b00_0100_0000,
		ST_OWNER = 10'b00_1000_0000,
		ST_FILL  = 10'b01_0000_0000,
		ST_OUT   = 10'b10_0000_0000
	} state_t;

	state_t                 state_q;
	page_t                  page_q, evp_q, clr_q;
	logic [OffsetWidth-1:0] off_q;
	frame_t                 frame_q, clock_q, fifo_q;
	logic [UsedW-1:0]       used_q;
	logic                   hit_q, fault_q, ev_q;

	// memories: page table {valid, frame}, frame owner, frame reference bit
	logic            map_we, own_we, ref_we, ref_wdata, ref_rd;
	page_t           map_addr, own_rd;
	logic [FrameW:0] map_wdata, map_rd;
	frame_t          own_addr, ref_addr;

	// memory port steering by state
	always_comb begin
		map_we    = 1'b0;
		map_addr  = page_q;
		map_wdata = '0;
		own_we    = 1'b0;
		own_addr  = frame_q;
		ref_we    = 1'b0;
		ref_addr  = frame_q;
		ref_wdata = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				map_we   = 1'b1;
				map_addr = clr_q;
				ref_we   = 1'b1;
				ref_addr = clr_q[FrameW-1:0];
			end
			// owner of the FIFO victim, ready in ST_INVAL
			ST_MAP: own_addr = fifo_q;
			ST_CLOCK: ref_addr = clock_q;
			ST_CREF: begin
				own_addr = clock_q;
				ref_addr = clock_q;
				ref_we   = ref_rd;
			end
			// evicted page loses its mapping
			ST_INVAL: begin
				map_we   = 1'b1;
				map_addr = own_rd;
			end
			ST_OWNER: begin
				map_we    = 1'b1;
				map_wdata = {1'b1, frame_q};
				own_we    = 1'b1;
			end
			ST_OUT: begin
				ref_we    = !pa.valid;
				ref_wdata = 1'b1;
			end
			default: ;
		endcase
	end

	tlbpt_ram #(.Width(FrameW + 1), .Depth(PageCount)) u_map (
		.clk(clk), .we(map_we), .addr(map_addr), .wdata(map_wdata), .rdata(map_rd));
	tlbpt_ram #(.Width(PageW), .Depth(FrameCount)) u_own (
		.clk(clk), .we(own_we), .addr(own_addr), .wdata(page_q), .rdata(own_rd));
	tlbpt_ram #(.Width(1), .Depth(FrameCount)) u_ref (
		.clk(clk), .we(ref_we), .addr(ref_addr), .wdata(ref_wdata), .rdata(ref_rd));

	assign page       = page_q;
	assign fill_frame = frame_q;
	assign tlb_step   = state_q == ST_FILL;
	assign tlb_mark   = state_q == ST_OUT && !pa.valid;
	assign va.ready   = state_q == ST_IDLE;

	always_ff @(posedge clk) begin
		if (va.valid && va.ready) begin
			off_q  <= va.data.virtual_address[OffsetWidth-1:0];
			page_q <= va.data.virtual_address[OffsetWidth +: PageW];
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && !pa.valid) begin
			pa.data.phys_addr     <= PaWidth'({frame_q, off_q});
			pa.data.frame_number  <= frame_q;
			pa.data.tlb_hit       <= hit_q;
			pa.data.page_fault    <= fault_q;
			pa.data.evicted_valid <= ev_q;
			pa.data.evicted_page  <= ev_q ? evp_q : '0;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			pa.valid <= 1'b0;
			clr_q    <= '0;
			used_q   <= '0;
			clock_q  <= '0;
			fifo_q   <= '0;
			hit_q    <= 1'b0;
			fault_q  <= 1'b0;
			ev_q     <= 1'b0;
			frame_q  <= '0;
			evp_q    <= '0;
		end else begin
			if (pa.valid && pa.ready) begin
				pa.valid <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == page_t'(PageCount - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (va.valid) begin
						state_q <= ST_LOOK;
					end
				end
				ST_LOOK: begin
					hit_q   <= tlb_hit;
					fault_q <= 1'b0;
					ev_q    <= 1'b0;
					if (tlb_hit) begin
						frame_q <= tlb_frame;
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_MAP;
					end
				end
				// page-table entry read is ready here
				ST_MAP: begin
					if (map_rd[FrameW]) begin
						frame_q <= map_rd[FrameW-1:0];
						state_q <= ST_FILL;
					end else begin
						fault_q <= 1'b1;
						if (used_q < UsedW'(FrameCount)) begin
							frame_q <= used_q[FrameW-1:0];
							used_q  <= used_q + 1'b1;
							state_q <= ST_OWNER;
						end else if (policy) begin
							frame_q <= fifo_q;
							fifo_q  <= fifo_q + 1'b1;
							ev_q    <= 1'b1;
							state_q <= ST_INVAL;
						end else begin
							ev_q    <= 1'b1;
							state_q <= ST_CLOCK;
						end
					end
				end
				// read the reference bit under the hand
				ST_CLOCK: begin
					state_q <= ST_CREF;
				end
				// set bit: cleared by the port steering, hand moves on
				ST_CREF: begin
					if (ref_rd) begin
						clock_q <= clock_q + 1'b1;
						state_q <= ST_CLOCK;
					end else begin
						frame_q <= clock_q;
						state_q <= ST_INVAL;
					end
				end
				ST_INVAL: begin
					// owner of the victim frame was read on the way in
					evp_q   <= own_rd;
					state_q <= ST_OWNER;
				end
				ST_OWNER: begin
					state_q <= ST_FILL;
				end
				ST_FILL: begin
					if (!tlb_hand_ref) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!pa.valid) begin
						pa.valid <= 1'b1;
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// ===== rtl/core/tlb_paging_translator_top.sv =====
// Top level: TLB paging translator
//  channel  | dir | contents
//  va       | in  | virtual_address
//  pa       | out | phys_addr, frame, flags, evicted page
//  cfg      | in  | cfg_we / cfg_wdata: replacement_policy
// Paths from accept to result valid: TLB hit; miss with mapping, where the TLB
// fill clock clears up to 16 TLB reference bits; fault on a free frame; FIFO
// victim; clock victim, the hand clearing the reference bits of up to 256 frames.
// Every miss path ends with a TLB fill. One item at a time.
// After reset a pass over the page table clears page-table valid and frame
// reference bits; input is not ready until it ends. TLB bits reset at once.
// A full result register holds the sequencer until the result is taken.
module tlb_paging_translator_top import tlbpt_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic cfg_wdata,
	tlbpt_va_if.sink   va,
	tlbpt_pa_if.source pa
);
	logic   policy_q;
	page_t  page;
	logic   mark, step, hit, hand_ref;
	frame_t fill_frame, hit_frame;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= 1'b0;
		end else if (cfg_we) begin
			policy_q <= cfg_wdata;
		end
	end

	tlbpt_tlb u_tlb (
		.clk(clk), .arst_n(arst_n), .page(page), .mark(mark), .step(step),
		.fill_frame(fill_frame), .hit(hit), .hit_frame(hit_frame),
		.hand_ref(hand_ref));

	tlbpt_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .policy(policy_q), .va(va), .pa(pa),
		.page(page), .tlb_mark(mark), .tlb_step(step), .fill_frame(fill_frame),
		.tlb_hit(hit), .tlb_frame(hit_frame), .tlb_hand_ref(hand_ref));
endmodule
